### design/dvhm_pkg.sv
// Shared types and constants for the distinct value histogram block.
// No dependencies; imported by every module of the block.
package dvhm_pkg;

  // Occurrence counters are 16 bits and saturate
  localparam int unsigned COUNT_W = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Control from the sequencer to the mode tracker
  typedef struct packed {
    logic clear;   // start of a set: forget the mode
    logic update;  // offer a new (slot, count, key) candidate
  } dvhm_mode_ctl_t;

endpackage

### design/dvhm_store.sv
// Key and count memories of the histogram table.
// One write port and one registered read port each; uses dvhm_pkg.
module dvhm_store #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  logic                                clk_i,
  input  logic                                rd_en_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0]      rd_addr_i,
  output logic [VALUE_BITS-1:0]               rd_key_o,
  output logic [dvhm_pkg::COUNT_W-1:0]        rd_cnt_o,
  input  logic                                key_we_i,
  input  logic                                cnt_we_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0]      wr_addr_i,
  input  logic [VALUE_BITS-1:0]               wr_key_i,
  input  logic [dvhm_pkg::COUNT_W-1:0]        wr_cnt_i
);
  import dvhm_pkg::*;

  logic [VALUE_BITS-1:0] key_mem [TABLE_DEPTH];
  logic [COUNT_W-1:0]    cnt_mem [TABLE_DEPTH];

  // Key memory
  always_ff @(posedge clk_i) begin
    if (key_we_i) begin
      key_mem[wr_addr_i] <= wr_key_i;
    end
    if (rd_en_i) begin
      rd_key_o <= key_mem[rd_addr_i];
    end
  end

  // Count memory, read alongside the key
  always_ff @(posedge clk_i) begin
    if (cnt_we_i) begin
      cnt_mem[wr_addr_i] <= wr_cnt_i;
    end
    if (rd_en_i) begin
      rd_cnt_o <= cnt_mem[rd_addr_i];
    end
  end

endmodule

### design/dvhm_mode.sv
// Running mode tracker: slot, count and key of the most frequent entry.
// Ties keep the lowest slot; uses dvhm_pkg.
module dvhm_mode #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  dvhm_pkg::dvhm_mode_ctl_t         ctl_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0]   slot_i,
  input  logic [dvhm_pkg::COUNT_W-1:0]     cnt_i,
  input  logic [VALUE_BITS-1:0]            key_i,
  output logic [dvhm_pkg::COUNT_W-1:0]     mode_hits_o,
  output logic [VALUE_BITS-1:0]            mode_key_o
);
  import dvhm_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

  logic [IDX_W-1:0]      slot_q, slot_d;
  logic [COUNT_W-1:0]    hits_q, hits_d;
  logic [VALUE_BITS-1:0] key_q, key_d;
  logic                  take;

  // Strictly more hits, or equal hits at a lower slot
  assign take = (cnt_i > hits_q) || ((cnt_i == hits_q) && (slot_i < slot_q));

  always_comb begin
    slot_d = slot_q;
    hits_d = hits_q;
    key_d  = key_q;
    if (ctl_i.clear) begin
      slot_d = '0;
      hits_d = '0;
    end else if (ctl_i.update && take) begin
      slot_d = slot_i;
      hits_d = cnt_i;
      key_d  = key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      hits_q <= '0;
    end else begin
      slot_q <= slot_d;
      hits_q <= hits_d;
    end
  end

  // Key of the mode entry; payload, no reset
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign mode_hits_o = hits_q;
  assign mode_key_o  = key_q;

endmodule

### design/distinct_value_histogram_mode.sv
// Distinct value histogram with running mode, top level.
// An empty table or a set start goes from acceptance straight to the update state; otherwise the
// keys are scanned in order through the memory read port, one entry per cycle, until a hit or the
// last entry held. A new sample is taken only after the last result is in the output register.
// Reset clears the table fill count and the mode; memories are not cleared.
// Depends on dvhm_pkg, dvhm_store and dvhm_mode.
module distinct_value_histogram_mode #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] sample_value_i,
  input  logic        first_of_set_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [9:0]  entry_index_o,
  output logic        is_new_o,
  output logic        table_full_o,
  output logic [10:0] distinct_total_o,
  output logic [31:0] mode_value_o,
  output logic [15:0] mode_count_o
);
  import dvhm_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_UPD   = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [VALUE_BITS-1:0] key_q, key_d;
  logic [CNT_W-1:0]      used_q, used_d;
  logic [IDX_W-1:0]      cmp_addr_q, cmp_addr_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [COUNT_W-1:0]    cnt_q, cnt_d;
  logic                  hit_q, hit_d;
  logic [IDX_W-1:0]      res_idx_q, res_idx_d;
  logic                  res_new_q, res_new_d;
  logic                  res_full_q, res_full_d;

  logic                  out_valid_q, out_valid_d;
  logic [9:0]            out_idx_q;
  logic                  out_new_q, out_full_q;
  logic [10:0]           out_total_q;
  logic [31:0]           out_mval_q;
  logic [15:0]           out_mcnt_q;
  logic                  out_load;

  logic                  in_fire;
  logic [VALUE_BITS+31:0] sample_ext;
  logic [VALUE_BITS-1:0] sample_key;

  // Memory and mode tracker hookup
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [VALUE_BITS-1:0] rd_key;
  logic [COUNT_W-1:0]    rd_cnt;
  logic                  key_we, cnt_we;
  logic [IDX_W-1:0]      wr_addr;
  logic [COUNT_W-1:0]    wr_cnt;
  dvhm_mode_ctl_t        mode_ctl;
  logic [IDX_W-1:0]      mode_slot_in;
  logic [COUNT_W-1:0]    mode_cnt_in;
  logic [COUNT_W-1:0]    mode_hits;
  logic [VALUE_BITS-1:0] mode_key;
  logic [COUNT_W-1:0]    cnt_inc;

  logic [IDX_W+9:0]      idx_ext;
  logic [CNT_W+10:0]     total_ext;
  logic [VALUE_BITS+31:0] mkey_ext;

  // Only the low VALUE_BITS bits of a sample take part
  assign sample_ext = (VALUE_BITS + 32)'(sample_value_i);
  assign sample_key = sample_ext[VALUE_BITS-1:0];

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign cnt_inc    = (cnt_q == COUNT_MAX) ? COUNT_MAX : cnt_q + COUNT_W'(1);
  assign out_load   = (state_q == ST_DRAIN) && (!out_valid_q || out_ready_i);

  // Sequencer: accept, scan keys in order, update, hand off result
  always_comb begin
    state_d      = state_q;
    key_d        = key_q;
    used_d       = used_q;
    cmp_addr_d   = cmp_addr_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    hit_d        = hit_q;
    res_idx_d    = res_idx_q;
    res_new_d    = res_new_q;
    res_full_d   = res_full_q;
    rd_en        = 1'b0;
    rd_addr      = '0;
    key_we       = 1'b0;
    cnt_we       = 1'b0;
    wr_addr      = idx_q;
    wr_cnt       = cnt_inc;
    mode_ctl     = '0;
    mode_slot_in = idx_q;
    mode_cnt_in  = cnt_inc;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          key_d = sample_key;
          hit_d = 1'b0;
          if (first_of_set_i) begin
            used_d         = '0;
            mode_ctl.clear = 1'b1;
          end
          if (first_of_set_i || (used_q == '0)) begin
            state_d = ST_UPD;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = '0;
            cmp_addr_d = '0;
            state_d    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (rd_key == key_q) begin
          hit_d   = 1'b1;
          idx_d   = cmp_addr_q;
          cnt_d   = rd_cnt;
          state_d = ST_UPD;
        end else if ((CNT_W'(cmp_addr_q) + CNT_W'(1)) == used_q) begin
          hit_d   = 1'b0;
          state_d = ST_UPD;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = cmp_addr_q + IDX_W'(1);
          cmp_addr_d = cmp_addr_q + IDX_W'(1);
        end
      end
      ST_UPD: begin
        state_d = ST_DRAIN;
        if (hit_q) begin
          // Hit: bump the saturating count
          cnt_we          = 1'b1;
          mode_ctl.update = 1'b1;
          res_idx_d       = idx_q;
          res_new_d       = 1'b0;
          res_full_d      = 1'b0;
        end else if (used_q < DEPTH_C) begin
          // Miss with room: append with count 1
          key_we          = 1'b1;
          cnt_we          = 1'b1;
          wr_addr         = used_q[IDX_W-1:0];
          wr_cnt          = COUNT_W'(1);
          mode_ctl.update = 1'b1;
          mode_slot_in    = used_q[IDX_W-1:0];
          mode_cnt_in     = COUNT_W'(1);
          used_d          = used_q + CNT_W'(1);
          res_idx_d       = used_q[IDX_W-1:0];
          res_new_d       = 1'b1;
          res_full_d      = 1'b0;
        end else begin
          // Table full: drop
          res_idx_d  = '0;
          res_new_d  = 1'b0;
          res_full_d = 1'b1;
        end
      end
      ST_DRAIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
    end
  end

  // Working registers of the current transaction
  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    cmp_addr_q <= cmp_addr_d;
    idx_q      <= idx_d;
    cnt_q      <= cnt_d;
    hit_q      <= hit_d;
    res_idx_q  <= res_idx_d;
    res_new_q  <= res_new_d;
    res_full_q <= res_full_d;
  end

  // Output register, fit to the port widths
  assign idx_ext   = (IDX_W + 10)'(res_idx_q);
  assign total_ext = (CNT_W + 11)'(used_q);
  assign mkey_ext  = (VALUE_BITS + 32)'(mode_key);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_idx_q   <= idx_ext[9:0];
      out_new_q   <= res_new_q;
      out_full_q  <= res_full_q;
      out_total_q <= total_ext[10:0];
      out_mval_q  <= mkey_ext[31:0];
      out_mcnt_q  <= mode_hits;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign entry_index_o    = out_idx_q;
  assign is_new_o         = out_new_q;
  assign table_full_o     = out_full_q;
  assign distinct_total_o = out_total_q;
  assign mode_value_o     = out_mval_q;
  assign mode_count_o     = out_mcnt_q;

  dvhm_store #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_BITS  (VALUE_BITS)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_key_o  (rd_key),
    .rd_cnt_o  (rd_cnt),
    .key_we_i  (key_we),
    .cnt_we_i  (cnt_we),
    .wr_addr_i (wr_addr),
    .wr_key_i  (key_q),
    .wr_cnt_i  (wr_cnt)
  );

  dvhm_mode #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_BITS  (VALUE_BITS)
  ) u_mode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (mode_ctl),
    .slot_i      (mode_slot_in),
    .cnt_i       (mode_cnt_in),
    .key_i       (key_q),
    .mode_hits_o (mode_hits),
    .mode_key_o  (mode_key)
  );

  // Fill count never passes the table depth
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= DEPTH_C)
    else $error("fill count beyond table depth");

  // A scan only runs over entries that are held
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (CNT_W'(cmp_addr_q) < used_q))
    else $error("scan address beyond fill count");

  // An append grows the table by exactly one
  a_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_UPD) && !hit_q && (used_q < DEPTH_C))
      |=> (used_q == $past(used_q) + CNT_W'(1)))
    else $error("append did not grow the table");

  // Every delivered result has a mode with a nonzero count
  a_mode_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mode_count_o != '0))
    else $error("result with empty mode");

endmodule

### sim/distinct_value_histogram_mode_tb.sv
// Testbench for distinct_value_histogram_mode: self-checking, with its own histogram predictor.
// Depends on dvhm_pkg and the distinct_value_histogram_mode RTL with its submodules; needs no other files.
module distinct_value_histogram_mode_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dvhm_pkg::*;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned VALUE_BITS  = 32;
  localparam int unsigned STALL_LIMIT = 8 * TABLE_DEPTH;
  localparam int unsigned IDLE_PCT    = 31;

  // One expected result
  typedef struct packed {
    logic [9:0]  entry_index;
    logic        is_new;
    logic        table_full;
    logic [10:0] distinct_total;
    logic [31:0] mode_value;
    logic [15:0] mode_count;
  } tally_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] sample_value_i;
  logic        first_of_set_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [9:0]  entry_index_o;
  logic        is_new_o;
  logic        table_full_o;
  logic [10:0] distinct_total_o;
  logic [31:0] mode_value_o;
  logic [15:0] mode_count_o;

  // Predictor state: distinct keys in order of first appearance, their counts, the mode
  logic [31:0] hist_keys   [TABLE_DEPTH];
  logic [15:0] hist_counts [TABLE_DEPTH];
  int          hist_used;
  int          mode_slot_q;
  logic [15:0] mode_hits_q;

  tally_t      pending_tallies[$];
  int          mismatch_cnt;
  int          stall_cycles;
  logic        no_idle;

  distinct_value_histogram_mode #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .sample_value_i  (sample_value_i),
    .first_of_set_i  (first_of_set_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .entry_index_o   (entry_index_o),
    .is_new_o        (is_new_o),
    .table_full_o    (table_full_o),
    .distinct_total_o(distinct_total_o),
    .mode_value_o    (mode_value_o),
    .mode_count_o    (mode_count_o)
  );

  always #2 clk_i = ~clk_i;

  // Look up one sample, update the histogram and mode, return what the block should report
  function automatic tally_t tally_sample(logic [31:0] value, logic first);
    tally_t r;
    int     hit_slot;
    int     cnt;
    int     slot;
    r = '0;
    if (first) begin
      hist_used   = 0;
      mode_slot_q = 0;
      mode_hits_q = '0;
    end
    hit_slot = -1;
    for (int j = 0; j < hist_used; j++) begin
      if (hist_keys[j] == value) begin
        hit_slot = j;
        break;
      end
    end
    slot = -1;
    if (hit_slot >= 0) begin
      if (hist_counts[hit_slot] != COUNT_MAX) hist_counts[hit_slot]++;
      slot = hit_slot;
      r.entry_index = 10'(hit_slot);
    end else if (hist_used < TABLE_DEPTH) begin
      hist_keys[hist_used]   = value;
      hist_counts[hist_used] = 16'd1;
      slot          = hist_used;
      r.entry_index = 10'(hist_used);
      r.is_new      = 1'b1;
      hist_used++;
    end else begin
      // full table: value dropped, state untouched
      r.table_full = 1'b1;
    end
    // strict greater wins; a tie only moves the mode to a lower slot
    if (slot >= 0) begin
      cnt = int'(hist_counts[slot]);
      if (cnt > int'(mode_hits_q) || (cnt == int'(mode_hits_q) && slot < mode_slot_q)) begin
        mode_hits_q = 16'(cnt);
        mode_slot_q = slot;
      end
    end
    r.distinct_total = 11'(hist_used);
    r.mode_value     = (hist_used > 0) ? hist_keys[mode_slot_q] : '0;
    r.mode_count     = mode_hits_q;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  // Send one sample: optional idle cycles, then hold valid until the transaction is taken
  task automatic push_sample(input logic [31:0] value, input logic first);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_value_i <= value;
    first_of_set_i <= first;
    do @(posedge clk_i); while (!in_ready_o);
    pending_tallies.push_back(tally_sample(value, first));
  endtask

  // Receiver stalls
  always @(negedge clk_i) begin
    out_ready_i <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    tally_t want;
    if (out_valid_o && out_ready_i) begin
      if (pending_tallies.size() == 0) begin
        $error("unexpected result: entry_index %0d, distinct_total %0d",
               entry_index_o, distinct_total_o);
        mismatch_cnt++;
      end else begin
        want = pending_tallies.pop_front();
        check_field("entry_index", 32'(want.entry_index), 32'(entry_index_o));
        check_field("is_new", 32'(want.is_new), 32'(is_new_o));
        check_field("table_full", 32'(want.table_full), 32'(table_full_o));
        check_field("distinct_total", 32'(want.distinct_total), 32'(distinct_total_o));
        check_field("mode_value", want.mode_value, mode_value_o);
        check_field("mode_count", 32'(want.mode_count), 32'(mode_count_o));
      end
    end
  end

  // Watchdog: too long without any transaction on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Field extremes, set starts, hits, ties, stream before any set start
  task automatic test_directed();
    push_sample(32'h0000_0000, 1'b0);  // no set start since reset
    push_sample(32'hFFFF_FFFF, 1'b0);
    push_sample(32'hFFFF_FFFF, 1'b0);  // slot 1 leads
    push_sample(32'h0000_0000, 1'b0);  // tie at a lower slot takes the mode
    push_sample(32'h8000_0000, 1'b0);
    push_sample(32'h0000_0001, 1'b0);
    push_sample(32'h7FFF_FFFF, 1'b0);
    push_sample(32'hAAAA_AAAA, 1'b0);
    push_sample(32'h5555_5555, 1'b0);
    push_sample(32'h5555_5555, 1'b0);
    push_sample(32'h5555_5555, 1'b0);  // clear leader
    push_sample(32'hFFFF_FFFF, 1'b0);  // tie at a lower slot again
    push_sample(32'h5555_5555, 1'b1);  // set start: becomes entry 0
    push_sample(32'h0000_0000, 1'b1);  // set of one
    push_sample(32'h0000_0000, 1'b1);
    push_sample(32'h0000_0000, 1'b0);
    push_sample(32'h1234_5678, 1'b0);
    push_sample(32'h1234_5678, 1'b0);  // tie at a higher slot keeps the mode
    push_sample(32'h1234_5678, 1'b0);
    push_sample(32'hFFFF_FFFF, 1'b1);
  endtask

  // Random sets drawn mostly from a small pool so hits and ties are frequent
  task automatic test_random_sets(input int n_items);
    logic [31:0] pool [8];
    int          sent;
    int          set_len;
    int          pool_len;
    logic        first;
    logic [31:0] value;
    sent = 0;
    while (sent < n_items) begin
      set_len  = $urandom_range(40, 1);
      pool_len = $urandom_range(8, 1);
      for (int p = 0; p < pool_len; p++) begin
        case ($urandom_range(9))
          0:       pool[p] = 32'h0000_0000;
          1:       pool[p] = 32'hFFFF_FFFF;
          default: pool[p] = $urandom;
        endcase
      end
      for (int k = 0; k < set_len && sent < n_items; k++) begin
        // mostly a clean start per set; sometimes a set runs on, or restarts mid-way
        first = (k == 0) ? ($urandom_range(7) != 0) : ($urandom_range(19) == 0);
        value = ($urandom_range(9) < 7) ? pool[$urandom_range(pool_len - 1)] : $urandom;
        no_idle = (sent >= 200 && sent < 260);
        push_sample(value, first);
        sent++;
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    sample_value_i = '0;
    first_of_set_i = 1'b0;
    out_ready_i    = 1'b0;
    no_idle        = 1'b0;
    mismatch_cnt   = 0;
    stall_cycles   = 0;
    hist_used      = 0;
    mode_slot_q    = 0;
    mode_hits_q    = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random_sets(560);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk_i);
    repeat (TABLE_DEPTH + 8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
